[design/jqt_pkg.sv]
// Shared types, codes and helpers for the job queue table.
package jqt_pkg;

    // command codes
    localparam logic [3:0] CMD_ENQ      = 4'd0;
    localparam logic [3:0] CMD_DEQ      = 4'd1;
    localparam logic [3:0] CMD_PROMOTE  = 4'd2;
    localparam logic [3:0] CMD_MODIFY   = 4'd3;
    localparam logic [3:0] CMD_CHANGE   = 4'd4;
    localparam logic [3:0] CMD_REORDER  = 4'd5;
    localparam logic [3:0] CMD_COUNT    = 4'd6;
    localparam logic [3:0] CMD_LIST_ID  = 4'd7;
    localparam logic [3:0] CMD_LIST_ORD = 4'd8;

    // result status codes
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_DUP  = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NONE = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    // reorder key selects
    localparam logic [2:0] KEY_ID  = 3'd1;
    localparam logic [2:0] KEY_PRI = 3'd2;
    localparam logic [2:0] KEY_TYP = 3'd3;
    localparam logic [2:0] KEY_CPU = 3'd4;
    localparam logic [2:0] KEY_MEM = 3'd5;

    // change attribute selects
    localparam logic [2:0] CHG_PRI = 3'd1;
    localparam logic [2:0] CHG_TYP = 3'd2;
    localparam logic [2:0] CHG_CPU = 3'd3;
    localparam logic [2:0] CHG_MEM = 3'd4;

    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  pri;
        logic [3:0]  typ;
        logic [15:0] cpu;
        logic [15:0] mem;
    } t_rec;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic sort_step;
        logic exec;
        logic lord_load;
        logic lscan_step;
        logic lscan_load;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [3:0] cmd;
        logic       sel_ok;
        logic       empty;
        logic       scan_done;
        logic       sort_done;
        logic       lscan_done;
        logic       out_last;
    } t_ctl_sts;

    // sort key of a record
    function automatic logic [15:0] rec_key(input t_rec r, input logic [2:0] sel);
        logic [15:0] k;
        case (sel)
            KEY_ID:  k = r.id;
            KEY_PRI: k = {12'd0, r.pri};
            KEY_TYP: k = {12'd0, r.typ};
            KEY_CPU: k = r.cpu;
            default: k = r.mem;
        endcase
        return k;
    endfunction

endpackage

[design/jqt_ctrl.sv]
// Sequencing state machine of the job queue table.
module jqt_ctrl import jqt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SORT  = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_LIST  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    CMD_ENQ, CMD_PROMOTE, CMD_MODIFY, CMD_CHANGE: n_state = S_SCAN;
                    CMD_REORDER:  n_state = i_sts.sel_ok ? S_SORT : S_EXEC;
                    CMD_LIST_ID,
                    CMD_LIST_ORD: n_state = i_sts.empty ? S_EXEC : S_LIST;
                    default:      n_state = S_EXEC;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_EXEC;
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_sts.sort_done) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_LIST: begin
                if (i_sts.cmd == CMD_LIST_ID) begin
                    o_cmd.lscan_step = 1'b1;
                    if (i_sts.lscan_done) begin
                        o_cmd.lscan_load = 1'b1;
                        n_state          = S_OUT;
                    end
                end else begin
                    o_cmd.lord_load = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = i_sts.out_last ? S_IDLE : S_LIST;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

[design/jqt_dp.sv]
// Record store, search, sort and result registers of the job queue table.
module jqt_dp import jqt_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_ctl_cmd       i_cmd,
    output t_ctl_sts       o_sts,
    input  logic [3:0]     i_cmd_code,
    input  t_rec           i_rec,
    input  logic [3:0]     i_positions,
    input  logic [2:0]     i_field_select,
    input  logic [15:0]    i_new_value,
    output logic [2:0]     o_status,
    output t_rec           o_rec,
    output logic [CW-1:0]  o_job_count,
    output logic           o_last
);

    localparam int PW = (AW > 4) ? AW + 1 : 5;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_rec          r_rec [DEPTH];
    t_rec          n_rec [DEPTH];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]    r_code;
    t_rec          r_in;
    logic [3:0]    r_pos;
    logic [2:0]    r_sel;
    logic [15:0]   r_val;
    logic [CW-1:0] r_idx;
    logic          r_found;
    logic [AW-1:0] r_fidx;
    logic [CW-1:0] r_pass;
    logic [CW-1:0] r_e;
    logic [15:0]   r_prev;
    logic          r_have_prev;
    logic [15:0]   r_best;
    logic [AW-1:0] r_best_idx;
    logic          r_best_ok;
    logic [2:0]    r_ostat;
    t_rec          r_orec;
    logic [CW-1:0] r_ocnt;
    logic          r_olast;

    t_rec          scan_rec;
    logic          scan_live;
    logic [AW-1:0] tgt;
    logic [PW-1:0] pos_x, fidx_x;
    t_rec          fnd;
    t_rec          upd;
    logic          chg_ok;
    logic [2:0]    x_stat;
    t_rec          x_rec;

    assign scan_rec  = r_rec[r_idx[AW-1:0]];
    assign scan_live = (r_idx < r_cnt);
    assign pos_x     = PW'(r_pos);
    assign fidx_x    = PW'(r_fidx);
    assign tgt       = (pos_x > fidx_x) ? '0 : AW'(fidx_x - pos_x);
    assign fnd       = r_rec[r_fidx];

    // status to controller
    assign o_sts.cmd        = r_code;
    assign o_sts.sel_ok     = (r_sel >= KEY_ID) && (r_sel <= KEY_MEM);
    assign o_sts.empty      = (r_cnt == '0);
    assign o_sts.scan_done  = r_found || !scan_live;
    assign o_sts.sort_done  = (r_pass == FULL);
    assign o_sts.lscan_done = !scan_live;
    assign o_sts.out_last   = r_olast;

    // change result for the found record
    always_comb begin
        upd    = fnd;
        chg_ok = 1'b1;
        case (r_sel)
            CHG_PRI: upd.pri = r_val[3:0];
            CHG_TYP: upd.typ = r_val[3:0];
            CHG_CPU: upd.cpu = r_val;
            CHG_MEM: upd.mem = r_val;
            default: chg_ok  = 1'b0;
        endcase
    end

    // next record store and command result
    always_comb begin
        for (int k = 0; k < DEPTH; k++) n_rec[k] = r_rec[k];
        n_cnt  = r_cnt;
        x_stat = ST_OK;
        x_rec  = '0;
        if (i_cmd.sort_step) begin
            // one odd-even transposition pass over the occupied entries
            for (int k = 0; k + 1 < DEPTH; k++) begin
                if ((k[0] == r_pass[0]) && (CW'(k + 1) < r_cnt) &&
                    (rec_key(r_rec[k], r_sel) > rec_key(r_rec[k + 1], r_sel))) begin
                    n_rec[k]     = r_rec[k + 1];
                    n_rec[k + 1] = r_rec[k];
                end
            end
        end
        if (i_cmd.exec) begin
            case (r_code)
                CMD_ENQ: begin
                    if (r_found) x_stat = ST_DUP;
                    else if (r_cnt == FULL) x_stat = ST_FULL;
                    else begin
                        n_rec[r_cnt[AW-1:0]] = r_in;
                        n_cnt = r_cnt + 1'b1;
                        x_rec = r_in;
                    end
                end
                CMD_DEQ: begin
                    if (r_cnt == '0) x_stat = ST_NONE;
                    else begin
                        x_rec = r_rec[0];
                        for (int k = 0; k + 1 < DEPTH; k++) n_rec[k] = r_rec[k + 1];
                        n_cnt = r_cnt - 1'b1;
                    end
                end
                CMD_PROMOTE: begin
                    if (!r_found) x_stat = ST_NONE;
                    else begin
                        x_rec = fnd;
                        // shift the jobs between target and old place back by one
                        for (int k = 1; k < DEPTH; k++) begin
                            if (AW'(k) > tgt && AW'(k) <= r_fidx)
                                n_rec[k] = r_rec[k - 1];
                        end
                        n_rec[tgt] = fnd;
                    end
                end
                CMD_MODIFY: begin
                    if (!r_found) x_stat = ST_NONE;
                    else begin
                        x_rec    = r_in;
                        x_rec.id = fnd.id;
                        n_rec[r_fidx] = x_rec;
                    end
                end
                CMD_CHANGE: begin
                    if (!r_found) x_stat = ST_NONE;
                    else if (!chg_ok) begin
                        x_stat = ST_BAD;
                        x_rec  = fnd;
                    end else begin
                        x_rec = upd;
                        n_rec[r_fidx] = upd;
                    end
                end
                CMD_REORDER:  x_stat = o_sts.sel_ok ? ST_OK : ST_BAD;
                CMD_COUNT:    x_stat = ST_OK;
                CMD_LIST_ID,
                CMD_LIST_ORD: x_stat = ST_NONE;
                default:      x_stat = ST_BAD;
            endcase
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else          r_cnt <= n_cnt;
    end

    // records
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) r_rec[k] <= n_rec[k];
    end

    // command capture, walkers and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code      <= i_cmd_code;
            r_in        <= i_rec;
            r_pos       <= i_positions;
            r_sel       <= i_field_select;
            r_val       <= i_new_value;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_pass      <= '0;
            r_e         <= '0;
            r_have_prev <= 1'b0;
            r_best_ok   <= 1'b0;
        end
        if (i_cmd.scan_step && !r_found && scan_live) begin
            if (scan_rec.id == r_in.id) begin
                r_found <= 1'b1;
                r_fidx  <= r_idx[AW-1:0];
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.sort_step) r_pass <= r_pass + 1'b1;
        if (i_cmd.lscan_step && scan_live) begin
            if ((!r_have_prev || scan_rec.id > r_prev) &&
                (!r_best_ok || scan_rec.id < r_best)) begin
                r_best     <= scan_rec.id;
                r_best_idx <= r_idx[AW-1:0];
                r_best_ok  <= 1'b1;
            end
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.lscan_load) begin
            r_ostat     <= ST_OK;
            r_orec      <= r_rec[r_best_idx];
            r_ocnt      <= r_cnt;
            r_olast     <= (CW'(r_e + 1'b1) == r_cnt);
            r_prev      <= r_best;
            r_have_prev <= 1'b1;
            r_idx       <= '0;
            r_best_ok   <= 1'b0;
            r_e         <= r_e + 1'b1;
        end
        if (i_cmd.lord_load) begin
            r_ostat <= ST_OK;
            r_orec  <= r_rec[r_e[AW-1:0]];
            r_ocnt  <= r_cnt;
            r_olast <= (CW'(r_e + 1'b1) == r_cnt);
            r_e     <= r_e + 1'b1;
        end
        if (i_cmd.exec) begin
            r_ostat <= x_stat;
            r_orec  <= x_rec;
            r_ocnt  <= n_cnt;
            r_olast <= 1'b1;
        end
    end

    assign o_status    = r_ostat;
    assign o_rec       = r_orec;
    assign o_job_count = r_ocnt;
    assign o_last      = r_olast;

endmodule

[design/job_queue_table.sv]
// Top level of the job queue table: controller plus datapath.
// The block takes one command at a time and accepts the next only after the
// last result of the previous one has been transferred. Count, dequeue and a
// bad command go from dispatch straight to execution. Commands that address
// a job by id add a linear id search before execution. Reorder with a valid
// key adds DEPTH+1 odd-even passes, one per cycle. List in order loads each
// result from its place and then presents it. List by id walks all held jobs
// for each result to find the next larger id. An output stall holds the block
// until the result is taken. Records sit in flip-flops. Reset clears the
// occupancy but not the record contents.
module job_queue_table import jqt_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [3:0]                 i_cmd,
    input  logic [15:0]                i_job_id,
    input  logic [3:0]                 i_priority_req,
    input  logic [3:0]                 i_job_type,
    input  logic [15:0]                i_cpu_time,
    input  logic [15:0]                i_memory_used,
    input  logic [3:0]                 i_positions,
    input  logic [2:0]                 i_field_select,
    input  logic [15:0]                i_new_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_status,
    output logic [15:0]                o_out_job_id,
    output logic [3:0]                 o_out_priority,
    output logic [3:0]                 o_out_job_type,
    output logic [15:0]                o_out_cpu_time,
    output logic [15:0]                o_out_memory,
    output logic [$clog2(DEPTH+1)-1:0] o_job_count,
    output logic                       o_last
);

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;
    t_rec     in_rec;
    t_rec     out_rec;

    // pack the input record
    assign in_rec.id  = i_job_id;
    assign in_rec.pri = i_priority_req;
    assign in_rec.typ = i_job_type;
    assign in_rec.cpu = i_cpu_time;
    assign in_rec.mem = i_memory_used;

    jqt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (ctl_sts),
        .o_cmd   (ctl_cmd)
    );

    jqt_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctl_cmd),
        .o_sts          (ctl_sts),
        .i_cmd_code     (i_cmd),
        .i_rec          (in_rec),
        .i_positions    (i_positions),
        .i_field_select (i_field_select),
        .i_new_value    (i_new_value),
        .o_status       (o_status),
        .o_rec          (out_rec),
        .o_job_count    (o_job_count),
        .o_last         (o_last)
    );

    // unpack the result record
    assign o_out_job_id   = out_rec.id;
    assign o_out_priority = out_rec.pri;
    assign o_out_job_type = out_rec.typ;
    assign o_out_cpu_time = out_rec.cpu;
    assign o_out_memory   = out_rec.mem;

endmodule
